// ===== hdl/nmwu_pkg.sv =====
// Package for the neuron momentum weight update block: action and register codes,
// state and entry types, Q16.16 helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nmwu_pkg;

   // Item actions (codes six and seven mean nothing and act as read)
   typedef enum logic [2:0] {
      ACT_CLEAR = 3'd0,
      ACT_ACC_W = 3'd1,
      ACT_ACC_B = 3'd2,
      ACT_APPLY = 3'd3,
      ACT_READ  = 3'd4,
      ACT_RESET = 3'd5
   } action_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_LEARNING_RATE = 2'd0,
      CSR_DECAY_RATE    = 2'd1,
      CSR_MOMENTUM_RATE = 2'd2
   } csr_index_type;

   localparam logic [19:0] LEARNING_RATE_RESET = 20'd6554;
   localparam logic [15:0] DECAY_RATE_RESET    = 16'd0;
   localparam logic [15:0] MOMENTUM_RATE_RESET = 16'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FETCH,
      ST_LOAD,
      ST_ACC1,
      ST_ACC2,
      ST_ACC3,
      ST_ACC4,
      ST_ACC5,
      ST_RESP
   } state_type;

   // One memory entry: weight, its diff and its last diff
   typedef struct packed {
      logic signed [31:0] weight;
      logic signed [31:0] diff;
      logic signed [31:0] last;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) begin
         r = 32'sh7fffffff;
      end else if (x < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/nmwu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nmwu_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AddrW-1:0] raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/neuron_momentum_weight_update.sv =====
// Neuron training store: weight diffs with decay and momentum, Q16.16, one entry RAM.
// Items are taken one at a time: no new item is accepted until the result of the last
// one has been loaded into the output register. Accumulation runs as a five-step
// multiply chain; clear, apply and reset sweep every entry of the RAM.
// Reset (synchronous, active high) resets the control registers, then sweeps the RAM
// to zero, during which no item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module neuron_momentum_weight_update
   import nmwu_pkg::*;
#(
   parameter int NUM_WEIGHTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Item beats
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] action, [8:3] weight_index, [40:9] delta_value, [72:41] neuron_output
   input  wire logic [79:0] req_tdata,
   // Result beats
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] index_echo, [37:6] weight_value, [69:38] bias_value
   output logic [71:0]      rsp_tdata,
   // Register writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);

   localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
   localparam int CW = $clog2(NUM_WEIGHTS + 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(NUM_WEIGHTS);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type state_ff, state_in;
   logic [2:0]  act_ff;             // action of the item in flight
   logic [5:0]  idx_ff;
   logic signed [31:0] delta_ff;
   logic signed [31:0] outv_ff;
   logic        ok_ff;              // index lies inside the store
   logic        item_ff;            // a result is owed (low for the power-on sweep)
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        sweep_vld_ff;
   logic [AW-1:0] sweep_addr_ff;

   logic [19:0] lr_ff;
   logic [15:0] decay_ff;
   logic [15:0] mom_ff;

   logic signed [31:0] bias_ff, bias_in;
   logic signed [31:0] bias_diff_ff, bias_diff_in;
   logic signed [31:0] bias_last_ff, bias_last_in;

   entry_type          entry_ff;
   logic signed [52:0] lr_prod_ff, lr_prod_in;
   logic signed [31:0] p_ff, p_in;
   logic signed [48:0] dprod_ff, dprod_in;
   logic signed [48:0] mprod_ff, mprod_in;
   logic signed [63:0] gprod_ff, gprod_in;
   logic signed [32:0] d_ff, d_in;
   logic signed [32:0] m_ff, m_in;
   logic signed [32:0] term_ff, term_in;
   logic signed [34:0] part_ff, part_in;
   logic signed [31:0] res_w_ff, res_w_in;

   logic               rsp_valid_ff;
   logic [5:0]         rsp_idx_ff;
   logic signed [31:0] rsp_w_ff;
   logic signed [31:0] rsp_b_ff;

   // ------------------------------------------------------------------
   // Entry RAM
   // ------------------------------------------------------------------
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata, ram_rdata;

   nmwu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_WEIGHTS)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Arithmetic
   // ------------------------------------------------------------------
   logic               req_fire;
   logic               rsp_load;
   logic               is_bias;
   logic [AW-1:0]      idx_addr;
   logic signed [52:0] lr_rnd;
   logic signed [63:0] g_rnd;
   logic signed [31:0] g_sat;
   logic signed [31:0] val_sel;
   logic signed [31:0] last_sel;
   logic signed [31:0] diff_sel;
   logic signed [34:0] diff_sum;
   logic signed [31:0] new_diff;
   entry_type          sweep_data;

   assign req_fire = req_tvalid && req_tready;
   assign is_bias  = (act_ff == ACT_ACC_B);
   assign idx_addr = AW'(idx_ff);

   // Rounding is half up: add one half then shift down by sixteen
   assign lr_prod_in = 53'(signed'({1'b0, lr_ff})) * 53'(delta_ff);
   assign lr_rnd     = (lr_prod_ff + 53'sd32768) >>> 16;
   assign p_in       = sat32(64'(lr_rnd));

   // Bias accumulation uses the bias registers in place of the entry
   assign val_sel  = is_bias ? bias_ff      : ram_rdata.weight;
   assign last_sel = is_bias ? bias_last_ff : ram_rdata.last;
   assign diff_sel = is_bias ? bias_diff_ff : entry_ff.diff;

   assign dprod_in = 49'(signed'({1'b0, decay_ff})) * 49'(val_sel);
   assign mprod_in = 49'(signed'({1'b0, mom_ff})) * 49'(last_sel);
   assign gprod_in = 64'(p_ff) * 64'(outv_ff);
   assign d_in     = 33'((dprod_ff + 49'sd32768) >>> 16);
   assign m_in     = 33'((mprod_ff + 49'sd32768) >>> 16);

   assign g_rnd    = (gprod_ff + 64'sd32768) >>> 16;
   assign g_sat    = sat32(g_rnd);
   // Weight gradient descends, bias step ascends
   assign term_in  = is_bias ? 33'(p_ff) : -33'(g_sat);
   assign part_in  = 35'(diff_sel) - 35'(d_ff) + 35'(m_ff);

   assign diff_sum = part_ff + 35'(term_ff);
   assign new_diff = sat32(64'(diff_sum));

   // Sweep write-back per action; the power-on sweep runs as the reset action
   always_comb begin
      sweep_data = '0;
      unique case (act_ff)
         ACT_CLEAR: begin
            sweep_data.weight = ram_rdata.weight;
            sweep_data.diff   = '0;
            sweep_data.last   = ram_rdata.last;
         end
         ACT_APPLY: begin
            sweep_data.weight = sat32(64'(ram_rdata.weight) + 64'(ram_rdata.diff));
            sweep_data.diff   = ram_rdata.diff;
            sweep_data.last   = ram_rdata.diff;
         end
         default: begin
            sweep_data = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: next state, RAM strobes, bias and result updates
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_tready   = 1'b0;
      rsp_load     = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = idx_addr;
      ram_raddr    = idx_addr;
      ram_wdata    = sweep_data;
      bias_in      = bias_ff;
      bias_diff_in = bias_diff_ff;
      bias_last_in = bias_last_ff;
      res_w_in     = res_w_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_tvalid) begin
               unique case (req_tdata[2:0])
                  ACT_CLEAR: begin
                     bias_diff_in = '0;
                     state_in     = ST_SWEEP;
                  end
                  ACT_ACC_W, ACT_ACC_B: begin
                     state_in = ST_ACC1;
                  end
                  ACT_APPLY: begin
                     bias_in      = sat32(64'(bias_ff) + 64'(bias_diff_ff));
                     bias_last_in = bias_diff_ff;
                     state_in     = ST_SWEEP;
                  end
                  ACT_RESET: begin
                     bias_diff_in = '0;
                     bias_last_in = '0;
                     state_in     = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_FETCH;
                  end
               endcase
            end
         end

         ST_SWEEP: begin
            // Read entry n while writing back entry n-1
            ram_re    = (cnt_ff < LAST_CNT);
            ram_raddr = cnt_ff[AW-1:0];
            ram_we    = sweep_vld_ff;
            ram_waddr = sweep_addr_ff;
            if (ram_re) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (!ram_re && !sweep_vld_ff) begin
               state_in = item_ff ? ST_FETCH : ST_IDLE;
            end
         end

         ST_FETCH: begin
            ram_re   = ok_ff;
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            res_w_in = ok_ff ? ram_rdata.weight : '0;
            state_in = ST_RESP;
         end

         ST_ACC1: begin
            // A weight accumulation outside the store only reads
            if (!ok_ff && !is_bias) begin
               state_in = ST_FETCH;
            end else begin
               ram_re   = ok_ff;
               state_in = ST_ACC2;
            end
         end

         ST_ACC2: state_in = ST_ACC3;
         ST_ACC3: state_in = ST_ACC4;
         ST_ACC4: state_in = ST_ACC5;

         ST_ACC5: begin
            if (is_bias) begin
               bias_diff_in = new_diff;
            end else begin
               ram_we           = 1'b1;
               ram_wdata.weight = entry_ff.weight;
               ram_wdata.diff   = new_diff;
               ram_wdata.last   = entry_ff.last;
            end
            res_w_in = ok_ff ? entry_ff.weight : '0;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         act_ff       <= ACT_RESET;
         item_ff      <= 1'b0;
         ok_ff        <= 1'b0;
         cnt_ff       <= '0;
         sweep_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= LEARNING_RATE_RESET;
         decay_ff     <= DECAY_RATE_RESET;
         mom_ff       <= MOMENTUM_RATE_RESET;
         bias_ff      <= '0;
         bias_diff_ff <= '0;
         bias_last_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sweep_vld_ff <= (state_ff == ST_SWEEP) && ram_re;
         bias_ff      <= bias_in;
         bias_diff_ff <= bias_diff_in;
         bias_last_ff <= bias_last_in;
         if (req_fire) begin
            act_ff  <= req_tdata[2:0];
            item_ff <= 1'b1;
            ok_ff   <= (32'(req_tdata[8:3]) < NUM_WEIGHTS);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_LEARNING_RATE: lr_ff    <= csr_wdata;
               CSR_DECAY_RATE:    decay_ff <= csr_wdata[15:0];
               CSR_MOMENTUM_RATE: mom_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      sweep_addr_ff <= cnt_ff[AW-1:0];
      if (req_fire) begin
         idx_ff   <= req_tdata[8:3];
         delta_ff <= req_tdata[40:9];
         outv_ff  <= req_tdata[72:41];
      end
      if (state_ff == ST_ACC1) begin
         lr_prod_ff <= lr_prod_in;
      end
      if (state_ff == ST_ACC2) begin
         entry_ff <= ram_rdata;
         p_ff     <= p_in;
         dprod_ff <= dprod_in;
         mprod_ff <= mprod_in;
      end
      if (state_ff == ST_ACC3) begin
         gprod_ff <= gprod_in;
         d_ff     <= d_in;
         m_ff     <= m_in;
      end
      if (state_ff == ST_ACC4) begin
         term_ff <= term_in;
         part_ff <= part_in;
      end
      res_w_ff <= res_w_in;
      if (rsp_load) begin
         rsp_idx_ff <= idx_ff;
         rsp_w_ff   <= res_w_ff;
         rsp_b_ff   <= bias_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_b_ff, rsp_w_ff, rsp_idx_ff};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE))
      else $error("entry RAM written while idle");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (cnt_ff <= LAST_CNT))
      else $error("sweep counter past the last entry");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second item taken while one is in flight");

   a_result_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("result beat raised outside the result step");

endmodule

`default_nettype wire
